// ===== sv/oppf_pkg.sv =====
`default_nettype none

package oppf_pkg;

    // Widths fixed by the character and table formats.
    localparam int SYM_W       = 8;
    localparam int CLS_W       = 3;
    localparam int KIND_W      = 2;
    localparam int VC_W        = 6;
    localparam int TABLE_W     = 36;
    localparam int TABLE_IDX_W = 6;
    localparam int DEPTH_DEF   = 63;

    localparam logic [TABLE_W-1:0] TABLE_RESET = 36'd1056598463;
    localparam logic [VC_W-1:0]    VALUE_MAX   = 6'd63;
    localparam logic [VC_W-1:0]    VALUE_MIN_OP = 6'd2;

    // Character codes.
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_END   = 8'h24;
    localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [SYM_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [SYM_W-1:0] CH_LO_Z  = 8'h7A;

    // Character classes; the order matches the rows and columns of the table.
    localparam logic [CLS_W-1:0] CLS_LETTER = 3'd0;
    localparam logic [CLS_W-1:0] CLS_PLUS   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_MINUS  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_STAR   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_SLASH  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_END    = 3'd5;
    localparam logic [CLS_W-1:0] CLS_BAD    = 3'd6;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SYM    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // Shift control broadcast to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    function automatic logic [CLS_W-1:0] classify(input logic [SYM_W-1:0] c);
        logic [CLS_W-1:0] cls;
        if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
            cls = CLS_LETTER;
        end else begin
            case (c)
                CH_PLUS:  cls = CLS_PLUS;
                CH_MINUS: cls = CLS_MINUS;
                CH_STAR:  cls = CLS_STAR;
                CH_SLASH: cls = CLS_SLASH;
                CH_END:   cls = CLS_END;
                default:  cls = CLS_BAD;
            endcase
        end
        return cls;
    endfunction

    // Reduce bit for stack-top class row against incoming class col.
    function automatic logic reduce_bit(input logic [TABLE_W-1:0] tbl,
                                        input logic [CLS_W-1:0]   row,
                                        input logic [CLS_W-1:0]   col);
        logic [TABLE_IDX_W-1:0] idx;
        logic                   bit_out;
        idx = {3'b000, row} * 6'd6 + {3'b000, col};
        if (idx > 6'd35) begin
            bit_out = 1'b0;
        end else begin
            bit_out = tbl[idx];
        end
        return bit_out;
    endfunction

endpackage

`default_nettype wire

// ===== sv/operator_precedence_infix_to_postfix.sv =====
// Operator-precedence infix-to-postfix converter.
// Input channel (i_valid/o_ready/i_symbol) takes one character per transaction:
// letters are operands, + - * / operators, '$' ends the expression. Output
// channel (o_valid/i_ready) delivers results: a postfix symbol (kind 0), accept
// (kind 1) or reject (kind 2); o_last marks the final result of a character.
// The stack is a chain of shift cells with the top in the first cell.
// A character is taken in S_IDLE; then each S_WORK cycle pops and emits one
// symbol unless the receiver stalls, and a last S_WORK step either pushes the
// character (no result) or gives the verdict; the next character is taken
// after that. The first result reaches the output register from S_WORK, after
// the character's acceptance. A stalled receiver holds the output register and
// freezes the pop sequence; nothing is lost.
// Any verdict clears the stack and the value count; the precedence table is
// kept. The 36-bit table is written over APB at address 0 (64-bit data).
// Reset empties the stack, clears the counts and output, and loads the default
// table; no clearing pass is needed.
`default_nettype none

module operator_precedence_infix_to_postfix #(
    parameter int STACK_DEPTH = oppf_pkg::DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_symbol,
    // Output channel.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [7:0]  o_out_symbol,
    output logic      [1:0]  o_kind,
    output logic             o_last,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    import oppf_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    typedef enum logic {
        S_IDLE,
        S_WORK
    } t_state;

    t_state              r_state, n_state;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [CLS_W-1:0]    r_cls, n_cls;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [VC_W-1:0]     r_vc, n_vc;
    logic                r_o_valid, n_o_valid;
    logic [SYM_W-1:0]    r_o_sym, n_o_sym;
    logic [KIND_W-1:0]   r_o_kind, n_o_kind;
    logic                r_o_last, n_o_last;
    logic [TABLE_W-1:0]  r_table;

    t_stk_ctl            w_ctl;
    logic [SYM_W-1:0]    w_top, w_next;
    logic [CLS_W-1:0]    w_top_cls, w_next_cls;
    logic                w_red, w_next_push, w_can, w_verdict, w_cfg_wr;

    // Stack of shift cells.
    oppf_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_push_data (r_sym),
        .o_top       (w_top),
        .o_next      (w_next)
    );

    // Configuration register write and read-back.
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[3] == 1'b0) ? {{(64-TABLE_W){1'b0}}, r_table} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table <= TABLE_RESET;
        end else if (w_cfg_wr && (paddr[3] == 1'b0)) begin
            r_table <= pwdata[TABLE_W-1:0];
        end
    end

    // Reduce decision for the current top and look-ahead for the entry below it.
    assign w_top_cls   = classify(w_top);
    assign w_next_cls  = classify(w_next);
    assign w_red       = (r_cnt != '0) && (w_top_cls < CLS_END)
                         && reduce_bit(r_table, w_top_cls, r_cls);
    assign w_next_push = (r_cnt == CNT_ONE) || (w_next_cls >= CLS_END)
                         || !reduce_bit(r_table, w_next_cls, r_cls);
    assign w_can       = !r_o_valid || i_ready;

    // One step of the parser per cycle while the output is not stalled.
    always_comb begin
        n_state   = r_state;
        n_sym     = r_sym;
        n_cls     = r_cls;
        n_cnt     = r_cnt;
        n_vc      = r_vc;
        n_o_valid = r_o_valid;
        n_o_sym   = r_o_sym;
        n_o_kind  = r_o_kind;
        n_o_last  = r_o_last;
        w_ctl     = '0;
        w_verdict = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym   = i_symbol;
                    n_cls   = classify(i_symbol);
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (w_can) begin
                    if (r_cls == CLS_BAD) begin
                        w_verdict = 1'b1;
                        n_o_kind  = KIND_REJECT;
                    end else if (w_red) begin
                        if ((w_top_cls == CLS_LETTER) ? (r_vc == VALUE_MAX)
                                                      : (r_vc < VALUE_MIN_OP)) begin
                            w_verdict = 1'b1;
                            n_o_kind  = KIND_REJECT;
                        end else begin
                            n_vc      = (w_top_cls == CLS_LETTER) ? r_vc + 1'b1
                                                                  : r_vc - 1'b1;
                            n_o_valid = 1'b1;
                            n_o_sym   = w_top;
                            n_o_kind  = KIND_SYM;
                            n_o_last  = (r_cls != CLS_END) && w_next_push;
                            w_ctl.pop = 1'b1;
                            n_cnt     = r_cnt - 1'b1;
                        end
                    end else if (r_cls == CLS_END) begin
                        w_verdict = 1'b1;
                        n_o_kind  = ((r_cnt == '0) && (r_vc == VC_W'(1))) ? KIND_ACCEPT
                                                                         : KIND_REJECT;
                    end else if (r_cnt >= CNT_FULL) begin
                        w_verdict = 1'b1;
                        n_o_kind  = KIND_REJECT;
                    end else begin
                        w_ctl.push = 1'b1;
                        n_cnt      = r_cnt + 1'b1;
                        n_state    = S_IDLE;
                    end

                    // A verdict ends the expression.
                    if (w_verdict) begin
                        n_o_valid = 1'b1;
                        n_o_sym   = '0;
                        n_o_last  = 1'b1;
                        n_cnt     = '0;
                        n_vc      = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counters and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_vc      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_vc      <= n_vc;
            r_o_valid <= n_o_valid;
        end
        r_sym    <= n_sym;
        r_cls    <= n_cls;
        r_o_sym  <= n_o_sym;
        r_o_kind <= n_o_kind;
        r_o_last <= n_o_last;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_out_symbol = r_o_sym;
    assign o_kind       = r_o_kind;
    assign o_last       = r_o_last;

`ifndef SYNTHESIS
    // The stack never holds more entries than there are cells.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("stack count beyond depth");

    // A verdict always closes the character and carries no symbol.
    a_verdict_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_kind != KIND_SYM)) |-> (r_o_last && (r_o_sym == '0)))
        else $error("verdict result malformed");

    // After a verdict the stack and value count are empty.
    a_verdict_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_verdict |=> ((r_cnt == '0) && (r_vc == '0)))
        else $error("verdict did not clear state");

    // No new character is taken while the parser is still working.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WORK) |-> !o_ready)
        else $error("input ready while busy");
`endif

endmodule

`default_nettype wire

// ===== sv/oppf_cell.sv =====
`default_nettype none

module oppf_cell (
    input  wire logic                  i_clk,
    input  wire oppf_pkg::t_stk_ctl    i_ctl,
    input  wire logic [7:0]            i_above,
    input  wire logic [7:0]            i_below,
    output logic      [7:0]            o_data
);
    import oppf_pkg::*;

    logic [SYM_W-1:0] r_data;

    // A push takes the entry from the cell above, a pop the one from below.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_above;
        end else if (i_ctl.pop) begin
            r_data <= i_below;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== sv/oppf_stack.sv =====
`default_nettype none

module oppf_stack #(
    parameter int STACK_DEPTH = oppf_pkg::DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire oppf_pkg::t_stk_ctl    i_ctl,
    input  wire logic [7:0]            i_push_data,
    output logic      [7:0]            o_top,
    output logic      [7:0]            o_next
);
    import oppf_pkg::*;

    logic [SYM_W-1:0] w_data [STACK_DEPTH];

    // Cell 0 holds the top of the stack; deeper entries follow down the chain.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [SYM_W-1:0] w_above;
        logic [SYM_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_push_data;
        end else begin : g_inner_above
            assign w_above = w_data[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_below = '0;
        end else begin : g_inner_below
            assign w_below = w_data[g+1];
        end

        oppf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_data  (w_data[g])
        );
    end

    assign o_top  = w_data[0];
    assign o_next = w_data[1];

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import oppf_pkg::*;

    localparam int          RESET_CYCLES  = 6;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_CHARS   = 40;
    // A hang ends the run at this limit, well past what a slow correct run needs.
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam logic [3:0]  ADDR_PREC_TABLE = 4'd0;
    localparam logic [TABLE_W-1:0] TABLE_NONE = '0;
    localparam logic [TABLE_W-1:0] TABLE_ALL  = '1;

    // Idling per random phase: sender idle and receiver stall, in percent.
    localparam int SEND_IDLE [4]  = '{0, 87, 0, 19};
    localparam int RECV_STALL [4] = '{0, 0, 87, 19};

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {
        ROW_CHAR,
        ROW_CHECKED,
        ROW_TABLE
    } t_row_op;

    typedef struct {
        t_row_op            op;
        logic [SYM_W-1:0]   sym;
        int                 reps;
        logic [TABLE_W-1:0] tbl;
        logic [KIND_W-1:0]  kind;
    } t_stim_row;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic [7:0]  i_symbol = 8'h00;
    logic        i_ready  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'd0;
    logic [63:0] pwdata   = 64'd0;
    wire         o_ready;
    wire         o_valid;
    wire  [7:0]  o_out_symbol;
    wire  [1:0]  o_kind;
    wire         o_last;
    wire  [63:0] prdata;
    wire         pready;

    // Shadow copy of the converter state.
    logic [SYM_W-1:0]   shadow_stack [DEPTH_DEF];
    int                 shadow_depth = 0;
    int                 value_total  = 0;
    logic [TABLE_W-1:0] prec_bits    = TABLE_RESET;

    t_result     step_results [$];
    t_result     pending_results [$];
    t_result     oldest_result;
    t_stim_row   directed_rows [26];
    int          chars_sent     = 0;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        holding        = 1'b0;
    int unsigned cycle_count    = 0;
    event        hold_go;

    operator_precedence_infix_to_postfix i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_symbol     (i_symbol),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_symbol (o_out_symbol),
        .o_kind       (o_kind),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Character classes in the order of the precedence table rows and columns.
    function automatic logic [CLS_W-1:0] char_class(input logic [SYM_W-1:0] c);
        logic [CLS_W-1:0] cls;
        case (c) inside
            [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]: cls = CLS_LETTER;
            CH_PLUS:  cls = CLS_PLUS;
            CH_MINUS: cls = CLS_MINUS;
            CH_STAR:  cls = CLS_STAR;
            CH_SLASH: cls = CLS_SLASH;
            CH_END:   cls = CLS_END;
            default:  cls = CLS_BAD;
        endcase
        return cls;
    endfunction

    function automatic logic [SYM_W-1:0] rand_letter();
        if ($urandom_range(1) == 0) begin
            return CH_UP_A + 8'($urandom_range(25));
        end
        return CH_LO_A + 8'($urandom_range(25));
    endfunction

    function automatic logic [SYM_W-1:0] rand_operator();
        logic [SYM_W-1:0] op;
        case ($urandom_range(3))
            0:       op = CH_PLUS;
            1:       op = CH_MINUS;
            2:       op = CH_STAR;
            default: op = CH_SLASH;
        endcase
        return op;
    endfunction

    // A verdict ends the expression and empties the stack and the value count.
    task automatic close_expression(input logic [KIND_W-1:0] verdict_kind);
        step_results.push_back(t_result'({8'h00, verdict_kind, 1'b1}));
        shadow_depth = 0;
        value_total  = 0;
    endtask

    // Works out the results one character causes and advances the shadow state.
    task automatic convert_char(input logic [SYM_W-1:0] c);
        logic [CLS_W-1:0] cls;
        logic [CLS_W-1:0] top_cls;
        bit               popping;
        bit               stopped;
        t_result          tail;
        step_results.delete();
        cls     = char_class(c);
        popping = (cls != CLS_BAD);
        stopped = (cls == CLS_BAD);
        if (cls == CLS_BAD) begin
            close_expression(KIND_REJECT);
        end
        // Pop while the table says reduce for the top against this class.
        while (popping && shadow_depth > 0) begin
            top_cls = char_class(shadow_stack[shadow_depth - 1]);
            if (top_cls >= CLS_END || !prec_bits[top_cls * 6 + cls]) begin
                popping = 1'b0;
            end else if (top_cls == CLS_LETTER ? value_total >= int'(VALUE_MAX)
                                               : value_total < int'(VALUE_MIN_OP)) begin
                close_expression(KIND_REJECT);
                popping = 1'b0;
                stopped = 1'b1;
            end else begin
                value_total += (top_cls == CLS_LETTER) ? 1 : -1;
                step_results.push_back(t_result'({shadow_stack[shadow_depth - 1],
                                                  KIND_SYM, 1'b0}));
                shadow_depth--;
            end
        end
        if (stopped) begin
            return;
        end
        if (cls == CLS_END) begin
            close_expression((shadow_depth == 0 && value_total == 1) ? KIND_ACCEPT
                                                                     : KIND_REJECT);
        end else if (shadow_depth >= DEPTH_DEF) begin
            close_expression(KIND_REJECT);
        end else begin
            shadow_stack[shadow_depth] = c;
            shadow_depth++;
            if (step_results.size() > 0) begin
                tail      = step_results.pop_back();
                tail.last = 1'b1;
                step_results.push_back(tail);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %h, expected %h",
                 cycle_count, what, got, want);
    endtask

    // One input transaction, with an optional idle gap in front of it.
    task automatic send_char(input logic [SYM_W-1:0] c, input bit typed = 1'b0,
                             input logic [KIND_W-1:0] typed_kind = KIND_SYM);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid  <= 1'b1;
        i_symbol <= c;
        do @(posedge i_clk); while (!o_ready);
        convert_char(c);
        if (typed) begin
            pending_results.push_back(t_result'({8'h00, typed_kind, 1'b1}));
        end else begin
            foreach (step_results[k]) begin
                pending_results.push_back(step_results[k]);
            end
        end
        chars_sent++;
    endtask

    // Sends a character, or when the expression is to be broken, sometimes drops,
    // doubles or replaces it.
    task automatic emit(input logic [SYM_W-1:0] c, input bit broken);
        if (broken && $urandom_range(4) == 0) begin
            case ($urandom_range(2))
                0: ;
                1: send_char(8'($urandom_range(255)));
                default: begin
                    send_char(c);
                    send_char(c);
                end
            endcase
        end else begin
            send_char(c);
        end
    endtask

    // Mostly well-formed expressions with random letters and operators.
    task automatic send_expression();
        int  shape;
        int  terms;
        bit  broken;
        shape  = $urandom_range(99);
        broken = (shape >= 12 && shape < 32);
        if (shape < 12) begin
            send_char(8'($urandom_range(255)));
        end else begin
            terms = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            emit(rand_letter(), broken);
            for (int k = 1; k < terms; k++) begin
                emit(rand_operator(), broken);
                emit(rand_letter(), broken);
            end
            emit(CH_END, broken);
        end
    endtask

    // Drops valid, lets every expected result arrive and the block go quiet.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_prec_table(input logic [TABLE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PREC_TABLE;
        pwdata  <= 64'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        prec_bits = value;
    endtask

    // Receiver: random stalls, and a long hold-off while holding is set.
    always @(posedge i_clk) begin
        i_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_go);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    // Each output transaction is compared with the oldest expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, kind", 8'(o_kind), 8'h00);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_out_symbol !== oldest_result.sym) begin
                    report_mismatch("out_symbol", o_out_symbol, oldest_result.sym);
                end
                if (o_kind !== oldest_result.kind) begin
                    report_mismatch("kind", 8'(o_kind), 8'(oldest_result.kind));
                end
                if (o_last !== oldest_result.last) begin
                    report_mismatch("last", 8'(o_last), 8'(oldest_result.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int target;
        directed_rows = '{
            '{ROW_CHECKED, CH_END,   1,  TABLE_NONE, KIND_REJECT},  // end on an empty stack
            '{ROW_CHECKED, 8'h00,    1,  TABLE_NONE, KIND_REJECT},  // invalid, lowest code
            '{ROW_CHECKED, 8'hFF,    1,  TABLE_NONE, KIND_REJECT},  // invalid, highest code
            '{ROW_CHAR,    CH_UP_A,  1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_PLUS,  1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    8'h62,    1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_STAR,  1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_UP_Z,  1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_MINUS, 1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    8'h64,    1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_SLASH, 1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_LO_Z,  1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_END,   1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_PLUS,  1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHECKED, CH_END,   1,  TABLE_NONE, KIND_REJECT},  // operator with no values
            '{ROW_CHAR,    8'h71,    64, TABLE_NONE, KIND_SYM},     // builds 63 values
            '{ROW_CHECKED, 8'h71,    1,  TABLE_NONE, KIND_REJECT},  // value count overflow
            '{ROW_TABLE,   8'h00,    1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    8'h78,    63, TABLE_NONE, KIND_SYM},     // fills the stack
            '{ROW_CHECKED, CH_STAR,  1,  TABLE_NONE, KIND_REJECT},  // stack overflow
            '{ROW_CHAR,    8'h61,    1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHECKED, CH_END,   1,  TABLE_NONE, KIND_REJECT},  // end with one unreduced entry on the stack
            '{ROW_TABLE,   8'h00,    1,  TABLE_ALL,  KIND_SYM},
            '{ROW_CHAR,    8'h61,    1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    CH_PLUS,  1,  TABLE_NONE, KIND_SYM},
            '{ROW_CHAR,    8'h62,    1,  TABLE_NONE, KIND_SYM}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows with no idling.
        foreach (directed_rows[r]) begin
            case (directed_rows[r].op)
                ROW_TABLE: begin
                    wait_idle();
                    write_prec_table(directed_rows[r].tbl);
                end
                ROW_CHECKED: send_char(directed_rows[r].sym, 1'b1, directed_rows[r].kind);
                default: begin
                    repeat (directed_rows[r].reps) send_char(directed_rows[r].sym);
                end
            endcase
        end

        // Random phases; the sender drains before each table write.
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_prec_table(ph[0] ? {4'($urandom_range(15)), 32'($urandom())} : TABLE_RESET);
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target) send_expression();
        end

        // Long receiver hold-off so the block backs up into its input.
        wait_idle();
        write_prec_table(TABLE_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        target = chars_sent + PHASE_CHARS;
        while (chars_sent < target) send_expression();

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
